// ===== rtl/shp_pkg.sv =====
`timescale 1ns / 1ps
package shp_pkg;

  // Frame limits
  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_CHANNELS = 4;
  localparam int MAX_HEIGHT   = 4095;
  localparam int MIN_DIM      = 3;

  // Line store geometry
  localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int ROWLEN_W   = $clog2(LINE_DEPTH + 1);
  localparam int LAG_W      = $clog2(LINE_DEPTH + MAX_CHANNELS + 1);
  localparam int POS_W      = $clog2(LINE_DEPTH * MAX_HEIGHT + 1);

  // Clamped dimension widths and counter index widths
  localparam int W_W   = $clog2(MAX_WIDTH + 1);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int H_W   = $clog2(MAX_HEIGHT + 1);
  localparam int C_W   = $clog2(MAX_CHANNELS + 1);
  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // Payload and register field widths
  localparam int SAMPLE_W = 8;
  localparam int ACC_W    = SAMPLE_W + 4;
  localparam int CFG_W_W  = 12;
  localparam int CFG_H_W  = 12;
  localparam int CFG_C_W  = 3;
  localparam int DATA_W   = 32;

  // Register map
  localparam int REG_IDX_W = 2;
  localparam int PADDR_W   = REG_IDX_W + 2;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CHANNELS = 2'd2;

  localparam logic [CFG_W_W-1:0] RST_WIDTH    = 12'd640;
  localparam logic [CFG_H_W-1:0] RST_HEIGHT   = 12'd480;
  localparam logic [CFG_C_W-1:0] RST_CHANNELS = 3'd1;

  // Geometry recompute pipeline depth after a register write
  localparam int SETTLE_CYCLES = 3;
  localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

  // Kernel arithmetic
  localparam logic signed [ACC_W-1:0] CENTRE_GAIN = 12'sd5;
  localparam logic signed [ACC_W-1:0] PIX_MAX     = 12'sd255;

  // Frame geometry and control from the register block
  typedef struct packed {
    logic                 ready;
    logic                 abort;
    logic [COL_W-1:0]     w_m1;
    logic [H_W-1:0]       h_m1;
    logic [CH_W-1:0]      c_m1;
    logic [LINE_AW-1:0]   rowlen_m1;
    logic [LAG_W-1:0]     lag;
    logic [POS_W-1:0]     total;
  } shp_geom_t;

  // Per-channel window column: newest column plus the previous centre
  typedef struct packed {
    logic [SAMPLE_W-1:0] up;
    logic [SAMPLE_W-1:0] mid;
    logic [SAMPLE_W-1:0] down;
    logic [SAMPLE_W-1:0] prev_mid;
  } shp_col_t;

  function automatic int clamp_int(input int v, input int lo, input int hi);
    int r;
    r = v;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

// ===== rtl/shp_if.sv =====
`timescale 1ns / 1ps
// Input request channel: one channel element or a flush tick
interface shp_in_if import shp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                flush;

  modport source (output valid, output sample, output flush, input ready);
  modport sink (input valid, input sample, input flush, output ready);
endinterface

// Output request channel: one filtered element
interface shp_out_if import shp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] value;
  logic                frame_end;

  modport source (output valid, output value, output frame_end, input ready);
  modport sink (input valid, input value, input frame_end, output ready);
endinterface

// ===== rtl/sharpen_3x3_stream.sv =====
`timescale 1ns / 1ps
// Streaming 3x3 cross sharpen (5*centre minus the four neighbours, clamped to
// 0..255, border elements forced to 0). Samples arrive in raster order with
// channels interleaved; one element is taken per clock, every clock, as long
// as the result side keeps up. Both line stores share one simple dual-port
// RAM (upper and middle byte side by side), read once and written once per
// element, which sets the one-element-per-clock rate. A result passes through
// the window stage and then the output register before it leaves; results as a
// whole trail the input by one row plus one pixel, so after the last sample
// the source sends that many flush ticks (a sample past frame end counts as
// one) and the final element carries frame_end. A width, height or channel
// register write restarts the frame and blocks input while the geometry is
// recomputed; the same hold follows reset. The line stores are never cleared.
module sharpen_3x3_stream import shp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  shp_in_if.sink             samples,
  shp_out_if.source          results,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  shp_geom_t geom;

  // Frame position counters
  logic [POS_W-1:0]    in_pos;
  logic [LINE_AW-1:0]  line_idx;
  logic [CH_W-1:0]     in_ch;
  logic [CH_W-1:0]     out_ch;
  logic [COL_W-1:0]    out_col;
  logic [H_W-1:0]      out_row;

  // Accept stage decode
  logic                in_fire;
  logic                in_open;
  logic                s0_real;
  logic                s0_tail;
  logic                s0_gives;
  logic                s0_last;
  logic                s0_border;

  // Window stage
  logic                s1_valid;
  logic                s1_real;
  logic                s1_gives;
  logic                s1_interior;
  logic                s1_last;
  logic [CH_W-1:0]     s1_ch;
  logic [SAMPLE_W-1:0] s1_x;
  logic [LINE_AW-1:0]  s1_idx;
  logic                s1_move;

  // Line store RAM
  logic                  ram_we;
  logic                  ram_re;
  logic [LINE_AW-1:0]    ram_waddr;
  logic [LINE_AW-1:0]    ram_raddr;
  logic [2*SAMPLE_W-1:0] ram_wdata;
  logic [2*SAMPLE_W-1:0] ram_rdata;
  logic [SAMPLE_W-1:0]   ram_up;
  logic [SAMPLE_W-1:0]   ram_mid;

  // Window columns, one per channel
  shp_col_t            win [MAX_CHANNELS];
  shp_col_t            cur;

  logic signed [ACC_W-1:0] acc;
  logic [SAMPLE_W-1:0]     sat;

  // Output register
  logic                out_valid;
  logic [SAMPLE_W-1:0] out_value;
  logic                out_frame_end;

  shp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geom    (geom)
  );

  // Request classification
  assign in_fire   = samples.valid && samples.ready;
  assign in_open   = in_pos < geom.total;
  assign s0_real   = !samples.flush && in_open;
  assign s0_tail   = !in_open;
  assign s0_gives  = (s0_real && (in_pos >= POS_W'(geom.lag))) || s0_tail;
  assign s0_last   = s0_gives && (out_row == geom.h_m1) && (out_col == geom.w_m1)
                     && (out_ch == geom.c_m1);
  assign s0_border = (out_row == '0) || (out_row == geom.h_m1)
                     || (out_col == '0) || (out_col == geom.w_m1);

  // Stall only when a result is waiting on a full output register
  assign s1_move       = !s1_gives || !out_valid || results.ready;
  assign samples.ready = geom.ready && (!s1_valid || s1_move);

  // Position counters
  always_ff @(posedge clk) begin
    if (rst || geom.abort || (in_fire && s0_last)) begin
      in_pos   <= '0;
      line_idx <= '0;
      in_ch    <= '0;
      out_ch   <= '0;
      out_col  <= '0;
      out_row  <= '0;
    end else if (in_fire) begin
      if (s0_real) begin
        in_pos   <= in_pos + POS_W'(1);
        line_idx <= (line_idx == geom.rowlen_m1) ? '0 : line_idx + LINE_AW'(1);
        in_ch    <= (in_ch == geom.c_m1) ? '0 : in_ch + CH_W'(1);
      end
      if (s0_gives) begin
        if (out_ch == geom.c_m1) begin
          out_ch <= '0;
          if (out_col == geom.w_m1) begin
            out_col <= '0;
            out_row <= out_row + H_W'(1);
          end else begin
            out_col <= out_col + COL_W'(1);
          end
        end else begin
          out_ch <= out_ch + CH_W'(1);
        end
      end
    end
  end

  // Window stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || s1_move) begin
      s1_valid <= in_fire && (s0_real || s0_gives);
    end
  end

  // Window stage payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_real     <= s0_real;
      s1_gives    <= s0_gives;
      s1_interior <= s0_real && !s0_border;
      s1_last     <= s0_last;
      s1_ch       <= in_ch;
      s1_x        <= samples.sample;
      s1_idx      <= line_idx;
    end
  end

  // Line stores: read on accept, write back the shifted pair when the window stage moves on
  assign ram_re    = in_fire && s0_real;
  assign ram_raddr = line_idx;
  assign ram_we    = s1_valid && s1_move && s1_real;
  assign ram_waddr = s1_idx;
  assign ram_up    = ram_rdata[2*SAMPLE_W-1:SAMPLE_W];
  assign ram_mid   = ram_rdata[SAMPLE_W-1:0];
  assign ram_wdata = {ram_mid, s1_x};

  shp_ram #(
    .WIDTH (2 * SAMPLE_W),
    .DEPTH (LINE_DEPTH)
  ) u_lines (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Kernel: centre is the stored mid, right neighbour is the fresh mid
  assign cur = win[s1_ch];
  assign acc = CENTRE_GAIN * signed'(ACC_W'(cur.mid))
               - signed'(ACC_W'(cur.prev_mid))
               - signed'(ACC_W'(ram_mid))
               - signed'(ACC_W'(cur.up))
               - signed'(ACC_W'(cur.down));

  always_comb begin
    if (acc[ACC_W-1]) begin
      sat = '0;
    end else if (acc > PIX_MAX) begin
      sat = '1;
    end else begin
      sat = acc[SAMPLE_W-1:0];
    end
  end

  // Window shift for the element's channel
  always_ff @(posedge clk) begin
    if (s1_valid && s1_move && s1_real) begin
      win[s1_ch] <= '{up: ram_up, mid: ram_mid, down: s1_x, prev_mid: cur.mid};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_gives && s1_move) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_gives && s1_move) begin
      out_value     <= s1_interior ? sat : '0;
      out_frame_end <= s1_last;
    end
  end

  assign results.valid     = out_valid;
  assign results.value     = out_value;
  assign results.frame_end = out_frame_end;

`ifndef NO_ASSERTIONS
  // Read and write-back never hit the same line entry in one cycle
  a_ram_no_overlap: assert property (@(posedge clk) disable iff (rst)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("line store read and write collide");

  // The frame's last element restarts every position counter
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    in_fire && s0_last |=> in_pos == '0 && out_row == '0 && out_col == '0
      && out_ch == '0)
    else $error("positions not cleared after frame end");

  // Real samples never run past the frame size
  a_in_bound: assert property (@(posedge clk) disable iff (rst)
    geom.ready |-> in_pos <= geom.total)
    else $error("input position beyond frame");

  // The final element sits on the border
  a_end_is_border: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.frame_end |-> results.value == '0)
    else $error("frame end element not zero");
`endif

endmodule

// ===== rtl/shp_ram.sv =====
`timescale 1ns / 1ps
// Simple dual-port RAM, one write and one registered read per cycle
module shp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/shp_cfg.sv =====
`timescale 1ns / 1ps
// Register block: APB registers, clamping and derived frame geometry
module shp_cfg import shp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  output shp_geom_t          geom
);

  logic [CFG_W_W-1:0]   image_width;
  logic [CFG_H_W-1:0]   image_height;
  logic [CFG_C_W-1:0]   channel_count;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;
  logic                 reg_hit;

  logic [W_W-1:0]       w_c;
  logic [H_W-1:0]       h_c;
  logic [C_W-1:0]       c_c;
  logic [ROWLEN_W-1:0]  rowlen;
  logic [H_W-1:0]       h_b;
  logic [C_W-1:0]       c_b;
  logic [COL_W-1:0]     w_m1;
  logic [H_W-1:0]       h_m1;
  logic [CH_W-1:0]      c_m1;
  logic [LINE_AW-1:0]   rowlen_m1;
  logic [LAG_W-1:0]     lag;
  logic [POS_W-1:0]     total;
  logic [SETTLE_W-1:0]  settle;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  // Address decode for writes that land on a register
  always_comb begin
    unique case (reg_idx)
      REG_WIDTH, REG_HEIGHT, REG_CHANNELS: reg_hit = wr_en;
      default:                             reg_hit = 1'b0;
    endcase
  end

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= RST_WIDTH;
      image_height  <= RST_HEIGHT;
      channel_count <= RST_CHANNELS;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WIDTH:    image_width   <= pwdata[CFG_W_W-1:0];
        REG_HEIGHT:   image_height  <= pwdata[CFG_H_W-1:0];
        REG_CHANNELS: channel_count <= pwdata[CFG_C_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:    prdata = {{(DATA_W-CFG_W_W){1'b0}}, image_width};
      REG_HEIGHT:   prdata = {{(DATA_W-CFG_H_W){1'b0}}, image_height};
      REG_CHANNELS: prdata = {{(DATA_W-CFG_C_W){1'b0}}, channel_count};
      default:      prdata = '0;
    endcase
  end

  // Geometry pipeline: clamp, row length, frame size
  always_ff @(posedge clk) begin
    w_c <= W_W'(clamp_int(int'(image_width), MIN_DIM, MAX_WIDTH));
    h_c <= H_W'(clamp_int(int'(image_height), MIN_DIM, MAX_HEIGHT));
    c_c <= C_W'(clamp_int(int'(channel_count), 1, MAX_CHANNELS));

    rowlen <= ROWLEN_W'(w_c) * ROWLEN_W'(c_c);
    h_b    <= h_c;
    c_b    <= c_c;
    w_m1   <= COL_W'(w_c - W_W'(1));
    h_m1   <= h_c - H_W'(1);
    c_m1   <= CH_W'(c_c - C_W'(1));

    total     <= POS_W'(rowlen) * POS_W'(h_b);
    lag       <= LAG_W'(rowlen) + LAG_W'(c_b);
    rowlen_m1 <= LINE_AW'(rowlen - ROWLEN_W'(1));
  end

  // Hold off requests until the geometry pipeline has refilled
  always_ff @(posedge clk) begin
    if (rst || reg_hit) begin
      settle <= SETTLE_W'(SETTLE_CYCLES);
    end else if (settle != '0) begin
      settle <= settle - SETTLE_W'(1);
    end
  end

  assign geom.ready     = (settle == '0);
  assign geom.abort     = reg_hit;
  assign geom.w_m1      = w_m1;
  assign geom.h_m1      = h_m1;
  assign geom.c_m1      = c_m1;
  assign geom.rowlen_m1 = rowlen_m1;
  assign geom.lag       = lag;
  assign geom.total     = total;

endmodule

// ===== tb/shp_check.sv =====
`timescale 1ns / 1ps
// Watches both request channels and the register port, predicts every
// sharpened element and compares it with what the block delivers.
module shp_check import shp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  shp_in_if                  in_ch,
  shp_out_if                 out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output int                 errors,
  output int                 pending
);

  localparam int GAIN = 5;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                frame_end;
  } pixel_t;

  // Register copies
  logic [CFG_W_W-1:0] width_reg;
  logic [CFG_H_W-1:0] height_reg;
  logic [CFG_C_W-1:0] chan_reg;

  // Line stores, window [column age][row][channel], frame positions
  logic [SAMPLE_W-1:0] upper_mem [LINE_DEPTH];
  logic [SAMPLE_W-1:0] middle_mem [LINE_DEPTH];
  logic [SAMPLE_W-1:0] win [3][3][MAX_CHANNELS];
  logic [POS_W-1:0]    in_pos;
  logic [POS_W-1:0]    out_pos;

  pixel_t sharpened_q [$];

  function automatic int unsigned bound(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Any write to a known register restarts the frame
  function automatic void apply_write(logic [PADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    logic [REG_IDX_W-1:0] idx;
    idx = addr[PADDR_W-1:2];
    case (idx)
      REG_WIDTH:    width_reg = data[CFG_W_W-1:0];
      REG_HEIGHT:   height_reg = data[CFG_H_W-1:0];
      REG_CHANNELS: chan_reg = data[CFG_C_W-1:0];
      default:      return;
    endcase
    in_pos = '0;
    out_pos = '0;
  endfunction

  // One accepted request; returns 1 when it yields an element
  function automatic bit sharpen_element(logic [SAMPLE_W-1:0] x, logic fl, output pixel_t r);
    int unsigned w, h, c, rowlen, total, lag, k, j, ch, p, col, row;
    int acc;
    logic [SAMPLE_W-1:0] up, mid;
    w = bound(width_reg, MIN_DIM, MAX_WIDTH);
    h = bound(height_reg, MIN_DIM, MAX_HEIGHT);
    c = bound(chan_reg, 1, MAX_CHANNELS);
    rowlen = w * c;
    total = rowlen * h;
    lag = rowlen + c;
    r = '0;
    ch = 0;
    if (!fl && in_pos < total) begin
      k = in_pos;
      j = k % rowlen;
      ch = k % c;
      mid = middle_mem[j];
      up = upper_mem[j];
      upper_mem[j] = mid;
      middle_mem[j] = x;
      for (int s = 0; s < 3; s++) begin
        win[2][s][ch] = win[1][s][ch];
        win[1][s][ch] = win[0][s][ch];
      end
      win[0][0][ch] = up;
      win[0][1][ch] = mid;
      win[0][2][ch] = x;
      in_pos = k + 1;
      if (k < lag) return 0;
    end else if (!(in_pos >= total && out_pos < total)) begin
      // ignored flush or nothing pending
      return 0;
    end
    p = out_pos;
    col = (p / c) % w;
    row = p / rowlen;
    // tail elements and the border stay zero
    if ((in_pos < total || p < total - lag) &&
        row != 0 && row != h - 1 && col != 0 && col != w - 1) begin
      acc = GAIN * int'(win[1][1][ch]) - int'(win[2][1][ch]) - int'(win[0][1][ch])
            - int'(win[1][0][ch]) - int'(win[1][2][ch]);
      r.value = (acc < 0) ? 8'd0 : (acc > 255) ? 8'd255 : acc[7:0];
    end
    r.frame_end = (p == total - 1);
    out_pos = p + 1;
    if (r.frame_end) begin
      in_pos = '0;
      out_pos = '0;
    end
    return 1;
  endfunction

  always @(posedge clk) begin : watch
    pixel_t want;
    if (rst) begin
      width_reg = RST_WIDTH;
      height_reg = RST_HEIGHT;
      chan_reg = RST_CHANNELS;
      in_pos = '0;
      out_pos = '0;
      for (int a = 0; a < 3; a++)
        for (int b = 0; b < 3; b++)
          for (int q = 0; q < MAX_CHANNELS; q++) win[a][b][q] = '0;
      for (int i = 0; i < LINE_DEPTH; i++) begin
        upper_mem[i] = '0;
        middle_mem[i] = '0;
      end
      sharpened_q.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready) apply_write(paddr, pwdata);
      if (in_ch.valid && in_ch.ready) begin
        if (sharpen_element(in_ch.sample, in_ch.flush, want)) sharpened_q.push_back(want);
      end
      // compare against the oldest element still owed
      if (out_ch.valid && out_ch.ready) begin
        if (sharpened_q.size() == 0) begin
          $error("unexpected result: value %0d frame_end %0b", out_ch.value, out_ch.frame_end);
          errors++;
        end else begin
          want = sharpened_q.pop_front();
          if (out_ch.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, out_ch.value);
            errors++;
          end
          if (out_ch.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, got %0b", want.frame_end, out_ch.frame_end);
            errors++;
          end
        end
      end
    end
    pending = sharpened_q.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Drives frames of varying geometry through the sharpen block, with random
// gaps on both channels, and reports the verdict from the checker.
module tb import shp_pkg::*; ();

  localparam int RANDOM_ITEMS = 1700;
  localparam int HOLD_AT      = 100;
  localparam int HOLD_CYCLES  = 600;
  localparam int SETTLE_WAIT  = 8;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  int                 errors;
  int                 pending;

  shp_in_if  in_ch ();
  shp_out_if out_ch ();

  sharpen_3x3_stream dut (
    .clk     (clk),
    .rst     (rst),
    .samples (in_ch),
    .results (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  shp_check check_u (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .pready  (pready),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .errors  (errors),
    .pending (pending)
  );

  // Current geometry: raw channel value and the clamped use
  int  raw_c;
  int  eff_w, eff_h, eff_c;
  int  items;
  bit  src_calm;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb: errors");
    $finish;
  end

  function automatic int clampu(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Wait per request; calm stretches run with no gaps
  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 49) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  // Saturation shows up more often with the extremes weighted in
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Offer one request; called and returns at a falling edge
  task automatic send_req(logic [SAMPLE_W-1:0] s, logic fl);
    int gap;
    gap = draw_gap(src_calm);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= s;
    in_ch.flush <= fl;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Stop offering and let every owed element come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(int w, int h, int c);
    drain();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_CHANNELS, c);
    raw_c = c;
    eff_w = clampu(w & 12'hfff, MIN_DIM, MAX_WIDTH);
    eff_h = clampu(h & 12'hfff, MIN_DIM, MAX_HEIGHT);
    eff_c = clampu(c & 3'h7, 1, MAX_CHANNELS);
  endtask

  // One whole frame plus its tail; noisy adds stray flushes mid-frame,
  // samples in place of tail ticks and flushes with nothing pending
  task automatic run_frame(bit noisy);
    int total, lag;
    total = eff_w * eff_c * eff_h;
    lag = eff_w * eff_c + eff_c;
    for (int i = 0; i < total; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) send_req(SAMPLE_W'($urandom), 1'b1);
      send_req(pick_sample(), 1'b0);
      items++;
    end
    for (int i = 0; i < lag; i++) begin
      if (noisy && $urandom_range(0, 3) == 0) send_req(pick_sample(), 1'b0);
      else send_req(SAMPLE_W'($urandom), 1'b1);
      items++;
    end
    if (noisy && $urandom_range(0, 1) == 0) send_req(SAMPLE_W'($urandom), 1'b1);
  endtask

  // 3x3 single-channel frame: only the centre element is filtered
  task automatic cross_frame(logic [SAMPLE_W-1:0] centre, logic [SAMPLE_W-1:0] ring);
    for (int i = 0; i < 9; i++) send_req((i == 4) ? centre : ring, 1'b0);
    for (int i = 0; i < 4; i++) send_req(SAMPLE_W'($urandom), 1'b1);
  endtask

  // Part of a frame, then a register write that restarts it
  task automatic abort_frame();
    int total, part;
    total = eff_w * eff_c * eff_h;
    part = $urandom_range(1, total - 1);
    for (int i = 0; i < part; i++) begin
      send_req(pick_sample(), 1'b0);
      items++;
    end
    drain();
    write_reg(REG_CHANNELS, raw_c);
  endtask

  // Result side: random ready gaps and one long hold-off
  initial begin : result_sink
    int  gap;
    int  taken;
    bit  calm;
    taken = 0;
    calm = 1'b0;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = (taken == HOLD_AT) ? HOLD_CYCLES : draw_gap(calm);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
      taken++;
    end
  end

  initial begin : stimulus
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.flush = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    items = 0;
    src_calm = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: saturation both ways, flush with nothing pending
    configure(3, 3, 1);
    send_req(8'hff, 1'b1);
    cross_frame(8'd255, 8'd0);
    cross_frame(8'd0, 8'd255);
    cross_frame(8'd128, 8'd128);

    // Four channels (raw value above range), stray flushes, samples in tail
    configure(5, 4, 7);
    run_frame(1'b1);
    abort_frame();
    run_frame(1'b0);

    // Small geometry extremes and clamped register values
    configure(2, 0, 0);
    run_frame(1'b0);
    configure(1, 5, 1);
    run_frame(1'b0);
    configure(0, 0, 4);
    run_frame(1'b1);

    // Random frames, mostly small
    while (items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        configure(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10),
                  ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6),
                  $urandom_range(0, 7));
      end
      if ($urandom_range(0, 9) == 0) abort_frame();
      else run_frame($urandom_range(0, 3) == 0);
    end

    drain();
    if (errors == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
